[rtl/bcn_texture_block_decoder_defines.svh]
// Assertion macros for the BCn block decoder.
// Used by the top level; expects clk and rst_n in the enclosing scope.
`ifndef BCN_TEXTURE_BLOCK_DECODER_DEFINES_SVH
`define BCN_TEXTURE_BLOCK_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BCN_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcn: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BCN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bcn: next-cycle check failed");

`endif

[rtl/bcn_pkg.sv]
// Shared widths, codes and types for the BCn block decoder.
// No dependencies; used by every RTL module of the block.
package bcn_pkg;

  localparam int WORD_W       = 64;
  localparam int IN_DATA_W    = 2 * WORD_W;
  localparam int CHAN_W       = 8;
  localparam int OUT_FIELDS_W = 4 + 4 * CHAN_W;
  localparam int OUT_DATA_W   = 40;
  localparam int PAD_W        = OUT_DATA_W - OUT_FIELDS_W;
  localparam int NUM_W        = 11;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 3;
  localparam int QUEUE_DEPTH_DEF = 2;

  // format_mode codes
  localparam logic [2:0] FMT_BC1 = 3'd0;
  localparam logic [2:0] FMT_BC2 = 3'd1;
  localparam logic [2:0] FMT_BC3 = 3'd2;
  localparam logic [2:0] FMT_BC4 = 3'd3;
  localparam logic [2:0] FMT_BC5 = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd2;

  localparam logic [CFG_DATA_W-1:0] TRIM_MAX = 3'd4;

  // final step applied to a channel numerator
  typedef enum logic [1:0] {
    OP_PASS,
    OP_DIV3,
    OP_DIV5,
    OP_DIV7
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [NUM_W-1:0] num;
  } slot_t;

  // one classified block waiting for the pixel engine
  typedef struct packed {
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
    logic [2:0]        mode;
    logic [1:0]        col_last;
    logic [1:0]        row_last;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[rtl/bcn_front.sv]
// Front end: configuration registers, trim saturation, block intake.
// Depends on bcn_pkg; feeds bcn_fifo.
module bcn_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bcn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcn_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bcn_pkg::IN_DATA_W-1:0]  in_tdata,
  input  bcn_pkg::q_stat_t               q_stat,
  output logic                           q_push,
  output bcn_pkg::entry_t                q_entry
);

  logic [2:0] mode_r;
  logic [2:0] cols_r;
  logic [2:0] rows_r;
  logic [2:0] cols_eff;
  logic [2:0] rows_eff;
  logic       drop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= bcn_pkg::FMT_BC1;
      cols_r <= bcn_pkg::TRIM_MAX;
      rows_r <= bcn_pkg::TRIM_MAX;
    end else if (cfg_valid) begin
      case (cfg_index)
        bcn_pkg::CFG_FORMAT: mode_r <= cfg_data;
        bcn_pkg::CFG_COLS:   cols_r <= cfg_data;
        bcn_pkg::CFG_ROWS:   rows_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // trims above four saturate; a zero trim yields an empty block
  assign cols_eff = (cols_r > bcn_pkg::TRIM_MAX) ? bcn_pkg::TRIM_MAX : cols_r;
  assign rows_eff = (rows_r > bcn_pkg::TRIM_MAX) ? bcn_pkg::TRIM_MAX : rows_r;
  assign drop     = (cols_r == 3'd0) || (rows_r == 3'd0);

  assign in_tready = !q_stat.full;
  assign q_push    = in_tvalid && in_tready && !drop;

  always_comb begin
    q_entry.lo       = in_tdata[bcn_pkg::WORD_W-1:0];
    q_entry.hi       = in_tdata[bcn_pkg::IN_DATA_W-1:bcn_pkg::WORD_W];
    q_entry.mode     = mode_r;
    q_entry.col_last = cols_eff[1:0] - 2'd1;
    q_entry.row_last = rows_eff[1:0] - 2'd1;
  end

endmodule

[rtl/bcn_fifo.sv]
// Block queue between intake and pixel engine.
// Depends on bcn_pkg for the entry and status types.
module bcn_fifo #(
  parameter int DEPTH = bcn_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bcn_pkg::entry_t  push_entry,
  input  logic             pop,
  output bcn_pkg::entry_t  head,
  output bcn_pkg::q_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  bcn_pkg::entry_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    if (push && !pop)      count_nxt = count_r + CNT_W'(1);
    else if (pop && !push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == CNT_FULL);
  assign stat.empty = (count_r == '0);

endmodule

[rtl/bcn_back.sv]
// Pixel engine: walks the head block pixel by pixel through two stages.
// Depends on bcn_pkg; reads bcn_fifo, drives the output channel.
module bcn_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bcn_pkg::entry_t                head,
  input  bcn_pkg::q_stat_t               q_stat,
  output logic                           q_pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [bcn_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast
);

  localparam int NUM_W  = bcn_pkg::NUM_W;
  localparam int PROD_W = NUM_W + 12;
  // reciprocals: exact floor division over the numerator ranges used here
  localparam logic [PROD_W-1:0] RECIP3 = PROD_W'(683);   // >> 11
  localparam logic [PROD_W-1:0] RECIP5 = PROD_W'(1639);  // >> 13
  localparam logic [PROD_W-1:0] RECIP7 = PROD_W'(2341);  // >> 14

  function automatic bcn_pkg::slot_t colour_slot(input logic [7:0] e0, input logic [7:0] e1,
                                                 input logic [1:0] idx, input logic four);
    bcn_pkg::slot_t   s;
    logic [NUM_W-1:0] w0;
    logic [NUM_W-1:0] w1;
    w0    = NUM_W'(e0);
    w1    = NUM_W'(e1);
    s.op  = bcn_pkg::OP_PASS;
    s.num = '0;
    unique case (idx)
      2'd0: s.num = w0;
      2'd1: s.num = w1;
      2'd2: begin
        if (four) begin
          s.op  = bcn_pkg::OP_DIV3;
          s.num = (w0 << 1) + w1 + NUM_W'(1);
        end else begin
          s.num = (w0 + w1 + NUM_W'(1)) >> 1;
        end
      end
      2'd3: begin
        if (four) begin
          s.op  = bcn_pkg::OP_DIV3;
          s.num = w0 + (w1 << 1) + NUM_W'(1);
        end
      end
    endcase
    return s;
  endfunction

  function automatic bcn_pkg::slot_t interp_slot(input logic [7:0] a0, input logic [7:0] a1,
                                                 input logic [2:0] k);
    bcn_pkg::slot_t   s;
    logic [NUM_W-1:0] w0;
    logic [NUM_W-1:0] w1;
    logic [NUM_W-1:0] kk;
    w0    = NUM_W'(a0);
    w1    = NUM_W'(a1);
    kk    = NUM_W'(k);
    s.op  = bcn_pkg::OP_PASS;
    s.num = '0;
    if (k == 3'd0) begin
      s.num = w0;
    end else if (k == 3'd1) begin
      s.num = w1;
    end else if (a0 > a1) begin
      s.op  = bcn_pkg::OP_DIV7;
      s.num = (NUM_W'(8) - kk) * w0 + (kk - NUM_W'(1)) * w1;
    end else if (k == 3'd7) begin
      s.num = NUM_W'(255);
    end else if (k != 3'd6) begin
      s.op  = bcn_pkg::OP_DIV5;
      s.num = (NUM_W'(6) - kk) * w0 + (kk - NUM_W'(1)) * w1;
    end
    return s;
  endfunction

  function automatic logic [7:0] resolve(input bcn_pkg::slot_t s);
    logic [PROD_W-1:0] prod;
    logic [7:0]        v;
    prod = '0;
    v    = s.num[7:0];
    unique case (s.op)
      bcn_pkg::OP_PASS: v = s.num[7:0];
      bcn_pkg::OP_DIV3: begin
        prod = PROD_W'(s.num) * RECIP3;
        v    = prod[18:11];
      end
      bcn_pkg::OP_DIV5: begin
        prod = PROD_W'(s.num) * RECIP5;
        v    = prod[20:13];
      end
      bcn_pkg::OP_DIV7: begin
        prod = PROD_W'(s.num) * RECIP7;
        v    = prod[21:14];
      end
    endcase
    return v;
  endfunction

  // ---- stage A: pixel walk and numerator build ----
  logic [1:0] x_r, x_nxt;
  logic [1:0] y_r, y_nxt;
  logic [3:0] p;
  logic       a_fire;
  logic       a_last;
  logic       b_ready;
  logic       c_ready;

  logic [15:0]    c0, c1;
  logic [7:0]     e0 [3];
  logic [7:0]     e1 [3];
  logic [5:0]     cpos;
  logic [5:0]     kpos;
  logic [1:0]     cidx;
  logic [2:0]     k_lo, k_hi;
  logic [3:0]     nib;
  logic           four;
  bcn_pkg::slot_t sa [4];

  assign p      = {y_r, x_r};
  assign a_last = (x_r == head.col_last) && (y_r == head.row_last);
  assign a_fire = !q_stat.empty && b_ready;
  assign q_pop  = a_fire && a_last;

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (a_fire) begin
      if (x_r == head.col_last) begin
        x_nxt = 2'd0;
        y_nxt = (y_r == head.row_last) ? 2'd0 : y_r + 2'd1;
      end else begin
        x_nxt = x_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= 2'd0;
      y_r <= 2'd0;
    end else begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

  always_comb begin
    c0    = head.lo[15:0];
    c1    = head.lo[31:16];
    e0[0] = {c0[15:11], 3'b000};
    e0[1] = {c0[10:5], 2'b00};
    e0[2] = {c0[4:0], 3'b000};
    e1[0] = {c1[15:11], 3'b000};
    e1[1] = {c1[10:5], 2'b00};
    e1[2] = {c1[4:0], 3'b000};
    cpos  = 6'd32 + {1'b0, p, 1'b0};
    kpos  = 6'd16 + {1'b0, p, 1'b0} + {2'b00, p};
    cidx  = head.lo[cpos +: 2];
    k_lo  = head.lo[kpos +: 3];
    k_hi  = head.hi[kpos +: 3];
    nib   = head.hi[{p, 2'b00} +: 4];
    four  = (c0 > c1) || (head.mode != bcn_pkg::FMT_BC1);

    for (int i = 0; i < 4; i++) begin
      sa[i].op  = bcn_pkg::OP_PASS;
      sa[i].num = '0;
    end

    unique case (head.mode) inside
      bcn_pkg::FMT_BC1, bcn_pkg::FMT_BC2, bcn_pkg::FMT_BC3: begin
        for (int i = 0; i < 3; i++) begin
          sa[i] = colour_slot(e0[i], e1[i], cidx, four);
        end
        if (head.mode == bcn_pkg::FMT_BC2) begin
          sa[3].num = NUM_W'({nib, nib});      // 4-bit alpha times 17
        end else if (head.mode == bcn_pkg::FMT_BC3) begin
          sa[3] = interp_slot(head.hi[7:0], head.hi[15:8], k_hi);
        end
      end
      bcn_pkg::FMT_BC4: begin
        sa[0] = interp_slot(head.lo[7:0], head.lo[15:8], k_lo);
      end
      bcn_pkg::FMT_BC5: begin
        sa[0] = interp_slot(head.hi[7:0], head.hi[15:8], k_hi);
        sa[1] = interp_slot(head.lo[7:0], head.lo[15:8], k_lo);
      end
      default: ;
    endcase
  end

  // ---- stage B: numerators ----
  logic           b_valid_r;
  bcn_pkg::slot_t b_slot_r [4];
  logic [1:0]     b_col_r, b_row_r;
  logic           b_last_r;

  assign b_ready = !b_valid_r || c_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      b_slot_r <= sa;
      b_col_r  <= x_r;
      b_row_r  <= y_r;
      b_last_r <= a_last;
    end
  end

  // ---- stage C: output register ----
  logic       c_valid_r;
  logic [7:0] c_chan_r [4];
  logic [1:0] c_col_r, c_row_r;
  logic       c_last_r;

  assign c_ready = !c_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (c_ready) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && b_valid_r) begin
      for (int i = 0; i < 4; i++) begin
        c_chan_r[i] <= resolve(b_slot_r[i]);
      end
      c_col_r  <= b_col_r;
      c_row_r  <= b_row_r;
      c_last_r <= b_last_r;
    end
  end

  assign out_tvalid = c_valid_r;
  assign out_tlast  = c_last_r;
  assign out_tdata  = {{bcn_pkg::PAD_W{1'b0}}, c_chan_r[3], c_chan_r[2], c_chan_r[1],
                       c_chan_r[0], c_row_r, c_col_r};

endmodule

[rtl/bcn_texture_block_decoder.sv]
// Top level of the BCn (BC1..BC5) texture block decoder.
// Depends on bcn_pkg, bcn_front, bcn_fifo, bcn_back and the defines header.
//
// Usage:
//   in_*   : one transaction per compressed 4x4 block. in_tdata[63:0] holds block
//            bytes 0..7, in_tdata[127:64] bytes 8..15, little-endian.
//   out_*  : one transaction per decoded pixel, row order, out_tlast on the
//            final pixel of the block.
//   cfg_*  : register writes (0 format_mode, 1 block_cols, 2 block_rows), always
//            ready; write only while no block is in flight.
// Path: a block is written into the block queue; each pixel then passes the stage B
//   and stage C registers of the pixel engine before it appears on out_*.
// Throughput: one pixel per cycle while out_tready stays high, set by the single
//   per-pixel datapath of the pixel engine; a block yields block_cols*block_rows
//   pixels (16 for a full block). Blocks follow each other with no bubble.
// A zero trim accepts the block and emits nothing.
// Reset: format BC1, 4x4 trim, queue and pixel pipeline emptied.
// Stall: when out_tready is low the output holds; the engine keeps its place,
//   the block queue (QUEUE_DEPTH blocks) fills and then in_tready drops.
`include "bcn_texture_block_decoder_defines.svh"

module bcn_texture_block_decoder #(
  parameter int QUEUE_DEPTH = bcn_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bcn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcn_pkg::CFG_DATA_W-1:0] cfg_data,
  // block input
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bcn_pkg::IN_DATA_W-1:0]  in_tdata,  // block_low_word, block_high_word
  // pixel output
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // pixel_col, pixel_row, chan_zero, chan_one, chan_two, chan_three, 4 zero bits
  output logic [bcn_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast  // last_pixel
);

  bcn_pkg::q_stat_t q_stat;
  bcn_pkg::entry_t  q_entry;
  bcn_pkg::entry_t  q_head;
  logic             q_push;
  logic             q_pop;

  // intake: registers, trim, classification
  bcn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  // decouples intake from pixel emission
  bcn_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  // pixel engine; pops a block once its last pixel is issued
  bcn_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // engine never pops an empty queue, intake never pushes a full one
  `BCN_ASSERT_IMPLIES(a_pop_nonempty, q_pop, !q_stat.empty)
  `BCN_ASSERT_IMPLIES(a_push_room, q_push, !q_stat.full)
  // inside a block the next pixel is always already staged behind the output
  `BCN_ASSERT_NEXT(a_block_gapless, out_tvalid && out_tready && !out_tlast, out_tvalid)

endmodule

[bench/testbench.sv]
// Self-checking bench for bcn_texture_block_decoder: random and directed BC1..BC5 blocks.
// Each block's pixels are predicted in-bench and checked per field against the output stream.
// Depends on bcn_pkg and the decoder RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bcn_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 64;   // blocks with a zero trim leave no output to wait on
  localparam int RANDOM_PHASES = 12;
  localparam int CALM_PHASE    = 4;    // no idling on either side during this phase
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped index, write is a no-op

  typedef struct packed {
    logic [1:0] col;
    logic [1:0] row;
    logic [7:0] ch0;
    logic [7:0] ch1;
    logic [7:0] ch2;
    logic [7:0] ch3;
    logic       last;
  } pixel_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  // bench copy of the decoder registers, reset values
  logic [2:0] fmt_setting  = FMT_BC1;
  logic [2:0] cols_setting = 3'd4;
  logic [2:0] rows_setting = 3'd4;

  logic [IN_DATA_W-1:0] block_queue[$];   // blocks waiting to be driven
  pixel_t               pixel_fifo[$];    // decoded pixels still owed by the block
  int                   mismatches = 0;
  int                   cycles = 0;
  bit                   calm = 1'b0;

  bcn_texture_block_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- prediction

  // RGB565 endpoint channel, widened by plain left shift (no bit replication)
  function automatic int unsigned rgb565_chan(logic [15:0] c, int k);
    case (k)
      0:       return {c[15:11], 3'b000};
      1:       return {c[10:5], 2'b00};
      default: return {c[4:0], 3'b000};
    endcase
  endfunction

  // one color channel of pixel p; BC2/BC3 always use the four-color palette
  function automatic logic [7:0] colour_level(logic [63:0] w, bit forced, int p, int k);
    int unsigned e0, e1, v;
    logic [1:0]  sel;
    bit          four;
    e0   = rgb565_chan(w[15:0], k);
    e1   = rgb565_chan(w[31:16], k);
    sel  = w[32 + 2 * p +: 2];
    four = forced || (w[15:0] > w[31:16]);
    case (sel)
      2'd0:    v = e0;
      2'd1:    v = e1;
      2'd2:    v = four ? (2 * e0 + e1 + 1) / 3 : (e0 + e1 + 1) / 2;
      default: v = four ? (e0 + 2 * e1 + 1) / 3 : 0;   // black in three-color mode
    endcase
    return v[7:0];
  endfunction

  // interpolated channel: 8 levels when a0 > a1, else 6 levels plus 0 and 255
  function automatic logic [7:0] ramp_level(logic [63:0] w, int p);
    int unsigned a0, a1, k, v;
    a0 = w[7:0];
    a1 = w[15:8];
    k  = w[16 + 3 * p +: 3];
    if (k == 0)       v = a0;
    else if (k == 1)  v = a1;
    else if (a0 > a1) v = ((8 - k) * a0 + (k - 1) * a1) / 7;
    else if (k == 6)  v = 0;
    else if (k == 7)  v = 255;
    else              v = ((6 - k) * a0 + (k - 1) * a1) / 5;
    return v[7:0];
  endfunction

  // queue every pixel that one accepted block yields under the current settings
  function automatic void expect_block(logic [IN_DATA_W-1:0] blk);
    logic [63:0] lo, hi;
    int          cols, rows, p;
    pixel_t      px;
    lo   = blk[63:0];
    hi   = blk[127:64];
    cols = (cols_setting > TRIM_MAX) ? TRIM_MAX : cols_setting;
    rows = (rows_setting > TRIM_MAX) ? TRIM_MAX : rows_setting;
    for (int y = 0; y < rows; y++) begin
      for (int x = 0; x < cols; x++) begin
        // palette index always comes from the untrimmed 4x4 position
        p = 4 * y + x;
        px = '0;
        px.col  = x[1:0];
        px.row  = y[1:0];
        px.last = (y == rows - 1) && (x == cols - 1);
        case (fmt_setting)
          FMT_BC1, FMT_BC2, FMT_BC3: begin
            px.ch0 = colour_level(lo, fmt_setting != FMT_BC1, p, 0);
            px.ch1 = colour_level(lo, fmt_setting != FMT_BC1, p, 1);
            px.ch2 = colour_level(lo, fmt_setting != FMT_BC1, p, 2);
            if (fmt_setting == FMT_BC2) px.ch3 = {hi[4 * p +: 4], hi[4 * p +: 4]};  // x17
            else if (fmt_setting == FMT_BC3) px.ch3 = ramp_level(hi, p);
          end
          FMT_BC4: px.ch0 = ramp_level(lo, p);
          FMT_BC5: begin
            px.ch0 = ramp_level(hi, p);
            px.ch1 = ramp_level(lo, p);
          end
          default: ;  // unused format codes: position only, channels zero
        endcase
        pixel_fifo.push_back(px);
      end
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch %s: got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(string what, logic [7:0] got, logic [7:0] want);
    if (got !== want) flag_mismatch(what, 64'(got), 64'(want));
  endtask

  task automatic check_pixel();
    pixel_t want;
    if (pixel_fifo.size() == 0) begin
      flag_mismatch("pixel with none outstanding", 64'(out_tdata), 64'd0);
    end else begin
      want = pixel_fifo.pop_front();
      check_field("pixel_col", 8'(out_tdata[1:0]), 8'(want.col));
      check_field("pixel_row", 8'(out_tdata[3:2]), 8'(want.row));
      check_field("chan_zero", out_tdata[11:4], want.ch0);
      check_field("chan_one", out_tdata[19:12], want.ch1);
      check_field("chan_two", out_tdata[27:20], want.ch2);
      check_field("chan_three", out_tdata[35:28], want.ch3);
      check_field("tdata pad", 8'(out_tdata[39:36]), 8'h00);
      check_field("last_pixel", 8'(out_tlast), 8'(want.last));
    end
  endtask

  // ---------------------------------------------------------------- driver / monitor

  // block driver: one transaction per queued block, random gaps outside the calm phase
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) expect_block(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (block_queue.size() != 0 && (calm || $urandom_range(99) >= 26)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= block_queue.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // pixel monitor with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_pixel();
      out_tready <= calm || ($urandom_range(99) >= 26);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequencing

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [2:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_FORMAT: fmt_setting  = value;
      CFG_COLS:   cols_setting = value;
      CFG_ROWS:   rows_setting = value;
      default: ;
    endcase
  endtask

  task automatic configure(logic [2:0] fmt, logic [2:0] cols, logic [2:0] rows);
    write_reg(CFG_FORMAT, fmt);
    write_reg(CFG_COLS, cols);
    write_reg(CFG_ROWS, rows);
    cfg_valid <= 1'b0;
  endtask

  // sender holds off until every owed pixel is out, then lets in-flight blocks settle
  task automatic drain();
    while (block_queue.size() != 0 || in_tvalid || pixel_fifo.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [IN_DATA_W-1:0] random_block();
    logic [63:0] lo, hi;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    case ($urandom_range(9))
      0: lo[31:16] = lo[15:0];        // equal color endpoints
      1: begin                        // equal ramp endpoints
        lo[15:8] = lo[7:0];
        hi[15:8] = hi[7:0];
      end
      default: ;
    endcase
    return {hi, lo};
  endfunction

  function automatic logic [2:0] random_trim();
    return ($urandom_range(7) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4, 1));
  endfunction

  initial begin
    logic [2:0] fmt;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings (BC1, 4x4): four-color, three-color with black, equal endpoints
    block_queue.push_back({64'h0, 32'hE4E4E4E4, 16'h0000, 16'hFFFF});
    block_queue.push_back({64'h0, 32'hE4E4E4E4, 16'hFFFF, 16'h0000});
    block_queue.push_back('0);
    block_queue.push_back('1);
    drain();

    // BC2: c0 < c1 still four-color; explicit alpha extremes
    configure(FMT_BC2, 3'd4, 3'd4);
    block_queue.push_back({64'hFFFF_FFFF_FFFF_FFFF, 32'h1B1B1B1B, 16'hF800, 16'h07E0});
    block_queue.push_back({64'h0, 32'hE4E4E4E4, 16'h001F, 16'h001F});
    block_queue.push_back({64'hFEDC_BA98_7654_3210, 32'h4E4E4E4E, 16'h07E0, 16'hF800});
    drain();

    // BC3: eight-level, six-level with 0/255, equal alpha endpoints
    configure(FMT_BC3, 3'd4, 3'd4);
    block_queue.push_back({48'o7654321076543210, 8'h00, 8'hFF, 64'($urandom)});
    block_queue.push_back({48'o7654321076543210, 8'hFF, 8'h00, 32'hE4E4E4E4, 32'($urandom)});
    block_queue.push_back({48'o0123456701234567, 8'h80, 8'h80, 32'h1B1B1B1B, 32'($urandom)});
    drain();

    // BC4, single column
    configure(FMT_BC4, 3'd1, 3'd4);
    block_queue.push_back({64'($urandom), 48'o7654321076543210, 8'h10, 8'hF0});
    block_queue.push_back({64'($urandom), 48'o7654321076543210, 8'hF0, 8'h10});
    drain();

    // BC5, single row; channel 0 from the upper word
    configure(FMT_BC5, 3'd4, 3'd1);
    block_queue.push_back({48'o7654321076543210, 8'h20, 8'hE0,
                           48'o7654321076543210, 8'hE0, 8'h20});
    block_queue.push_back({48'o0123456701234567, 8'hE0, 8'h20,
                           48'o0123456701234567, 8'h20, 8'hE0});
    drain();

    // unused format with oversized trim saturating to 4x4
    configure(3'd7, 3'd7, 3'd5);
    block_queue.push_back(random_block());
    block_queue.push_back(random_block());
    drain();

    // zero trim: blocks are taken, nothing comes out; spare index must change nothing
    write_reg(CFG_SPARE, 3'd7);
    configure(3'd5, 3'd0, 3'd3);
    block_queue.push_back(random_block());
    block_queue.push_back(random_block());
    drain();
    configure(3'd6, 3'd3, 3'd0);
    block_queue.push_back(random_block());
    drain();

    // random phases; each boundary is a full drain before the next register writes
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      fmt = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      configure(fmt, random_trim(), random_trim());
      calm = (ph == CALM_PHASE);
      repeat (calm ? 40 : 27) block_queue.push_back(random_block());
      drain();
      calm = 1'b0;
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/bcn_pkg.sv
rtl/bcn_front.sv
rtl/bcn_fifo.sv
rtl/bcn_back.sv
rtl/bcn_texture_block_decoder.sv
bench/testbench.sv
